/* rtl/wfba_pkg.sv */
// Shared types, field widths and result status codes for the worst-fit block allocator.
package wfba_pkg;

    localparam int ADDR_W   = 21;
    localparam int SIZE_W   = 16;
    localparam int STATUS_W = 3;
    localparam int INDEX_W  = 5;

    localparam logic [STATUS_W-1:0] STATUS_LOADED   = 3'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL     = 3'd1;
    localparam logic [STATUS_W-1:0] STATUS_SPLIT    = 3'd2;
    localparam logic [STATUS_W-1:0] STATUS_UNSPLIT  = 3'd3;
    localparam logic [STATUS_W-1:0] STATUS_NO_FIT   = 3'd4;

    // One row of the block table
    typedef struct packed {
        logic [ADDR_W-1:0] start;
        logic [SIZE_W-1:0] size;
        logic              used;
    } entry_t;

    // Running best candidate of a table scan
    typedef struct packed {
        logic              found;
        logic [ADDR_W-1:0] start;
        logic [SIZE_W-1:0] size;
    } best_t;

endpackage

/* rtl/worst_fit_block_allocator.sv */
// Top level of the worst-fit block allocator: block table memory, sequencer and result register.
//
// Usage:
//   Input channel (item_valid / item_ready): operation 0 loads a free block of
//   size amount at the running end of the address space; operation 1 asks for
//   a block of at least amount. Each item gives exactly one result transfer on
//   the result channel (result_valid / result_ready): status, block_index,
//   block_start and block_size.
//   Sequence: a load's result is registered and valid in the cycle after its
//   transfer. An allocate scans the table through the single read port of the
//   table memory, one entry a cycle, then moves the later entries up one place
//   a cycle when the chosen block is split, then writes the remainder row and
//   then the chosen row.
//   Stall: a finished result waits in the output register; the next item is
//   taken while that register holds a result only if the receiver takes it in
//   the same cycle, and an allocate that ends early holds until it is free.
//   Reset: the table is empty and the next load starts at address zero; the
//   table memory itself is not cleared, as only rows below the count are read.
module worst_fit_block_allocator
    import wfba_pkg::*;
#(
    parameter int MAX_ENTRIES = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    output logic                item_ready,
    input  logic                operation,
    input  logic [SIZE_W-1:0]   amount,
    output logic                result_valid,
    input  logic                result_ready,
    output logic [STATUS_W-1:0] status,
    output logic [INDEX_W-1:0]  block_index,
    output logic [ADDR_W-1:0]   block_start,
    output logic [SIZE_W-1:0]   block_size
);

    localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_ENTRIES);

    typedef enum logic [6:0] {
        S_IDLE    = 7'b0000001,
        S_SCAN    = 7'b0000010,
        S_DECIDE  = 7'b0000100,
        S_SHIFT   = 7'b0001000,
        S_WR_REM  = 7'b0010000,
        S_WR_BEST = 7'b0100000,
        S_FINISH  = 7'b1000000
    } state_t;

    // Control state
    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  entry_count_reg, entry_count_next;
    logic [ADDR_W-1:0] next_load_start_reg, next_load_start_next;
    logic [CNT_W-1:0]  scan_idx_reg, scan_idx_next;
    logic              pipe_valid_reg, pipe_valid_next;
    logic              shift_active_reg, shift_active_next;
    logic              result_valid_reg, result_valid_next;

    // Payload state
    logic [IDX_W-1:0]    pipe_idx_reg, pipe_idx_next;
    logic [IDX_W-1:0]    shift_addr_reg, shift_addr_next;
    logic [SIZE_W-1:0]   amount_reg, amount_next;
    logic [STATUS_W-1:0] rs_status_reg, rs_status_next;
    logic [INDEX_W-1:0]  rs_index_reg, rs_index_next;
    logic [ADDR_W-1:0]   rs_start_reg, rs_start_next;
    logic [SIZE_W-1:0]   rs_size_reg, rs_size_next;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic [INDEX_W-1:0]  block_index_reg, block_index_next;
    logic [ADDR_W-1:0]   block_start_reg, block_start_next;
    logic [SIZE_W-1:0]   block_size_reg, block_size_next;

    // Table memory: one write and one registered read per cycle
    entry_t           table_mem [MAX_ENTRIES];
    entry_t           rd_data_reg;
    logic [IDX_W-1:0] rd_addr;
    logic             mem_we;
    logic [IDX_W-1:0] mem_waddr;
    entry_t           mem_wdata;

    // Compare unit
    logic             trk_clear;
    logic             trk_valid;
    best_t            best;
    logic [IDX_W-1:0] best_idx;
    logic [IDX_W-1:0] best_idx_p1;

    logic             item_xfer;
    logic             result_xfer;
    logic             out_free;
    logic             scan_issue;
    logic [CNT_W-1:0] count_m1;
    logic             table_full;

    // Widen a table position to the result index field, then keep its low bits
    function automatic logic [INDEX_W-1:0] to_index(input logic [IDX_W-1:0] idx);
        logic [IDX_W+INDEX_W-1:0] wide;
        wide = {{INDEX_W{1'b0}}, idx};
        return wide[INDEX_W-1:0];
    endfunction

    assign item_xfer   = item_valid && item_ready;
    assign result_xfer = result_valid_reg && result_ready;
    assign out_free    = !result_valid_reg || result_ready;
    assign item_ready  = (state_reg == S_IDLE) && out_free;
    assign table_full  = (entry_count_reg >= MAX_CNT);
    assign count_m1    = entry_count_reg - 1'b1;
    assign scan_issue  = (scan_idx_reg < entry_count_reg);
    assign best_idx_p1 = best_idx + 1'b1;
    assign trk_valid   = (state_reg == S_SCAN) && pipe_valid_reg;

    wfba_best #(
        .IDX_W (IDX_W)
    ) u_best (
        .clk      (clk),
        .rst_n    (rst_n),
        .clear    (trk_clear),
        .valid    (trk_valid),
        .idx      (pipe_idx_reg),
        .entry    (rd_data_reg),
        .amount   (amount_reg),
        .best     (best),
        .best_idx (best_idx)
    );

    always_comb
    begin
        state_next           = state_reg;
        entry_count_next     = entry_count_reg;
        next_load_start_next = next_load_start_reg;
        scan_idx_next        = scan_idx_reg;
        pipe_valid_next      = 1'b0;
        pipe_idx_next        = pipe_idx_reg;
        shift_active_next    = shift_active_reg;
        shift_addr_next      = shift_addr_reg;
        amount_next          = amount_reg;
        rs_status_next       = rs_status_reg;
        rs_index_next        = rs_index_reg;
        rs_start_next        = rs_start_reg;
        rs_size_next         = rs_size_reg;
        status_next          = status_reg;
        block_index_next     = block_index_reg;
        block_start_next     = block_start_reg;
        block_size_next      = block_size_reg;
        result_valid_next    = result_xfer ? 1'b0 : result_valid_reg;
        trk_clear            = 1'b0;
        rd_addr              = '0;
        mem_we               = 1'b0;
        mem_waddr            = '0;
        mem_wdata            = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (item_xfer)
                begin
                    if (!operation)
                    begin
                        result_valid_next = 1'b1;
                        if (table_full)
                        begin
                            status_next      = STATUS_FULL;
                            block_index_next = '0;
                            block_start_next = '0;
                            block_size_next  = '0;
                        end
                        else
                        begin
                            // Append a free block at the running end
                            mem_we               = 1'b1;
                            mem_waddr            = entry_count_reg[IDX_W-1:0];
                            mem_wdata.start      = next_load_start_reg;
                            mem_wdata.size       = amount;
                            mem_wdata.used       = 1'b0;
                            entry_count_next     = entry_count_reg + 1'b1;
                            next_load_start_next = next_load_start_reg
                                                   + {{(ADDR_W-SIZE_W){1'b0}}, amount};
                            status_next          = STATUS_LOADED;
                            block_index_next     = to_index(entry_count_reg[IDX_W-1:0]);
                            block_start_next     = next_load_start_reg;
                            block_size_next      = amount;
                        end
                    end
                    else
                    begin
                        amount_next   = amount;
                        scan_idx_next = '0;
                        trk_clear     = 1'b1;
                        state_next    = S_SCAN;
                    end
                end
            end

            S_SCAN:
            begin
                // Issue one read a cycle; the compare unit sees it in the cycle after
                rd_addr         = scan_idx_reg[IDX_W-1:0];
                pipe_valid_next = scan_issue;
                pipe_idx_next   = scan_idx_reg[IDX_W-1:0];
                if (scan_issue)
                begin
                    scan_idx_next = scan_idx_reg + 1'b1;
                end
                else if (!pipe_valid_reg)
                begin
                    state_next = S_DECIDE;
                end
            end

            S_DECIDE:
            begin
                if (!best.found)
                begin
                    rs_status_next = STATUS_NO_FIT;
                    rs_index_next  = '0;
                    rs_start_next  = '0;
                    rs_size_next   = '0;
                    state_next     = S_FINISH;
                end
                else
                begin
                    rs_index_next = to_index(best_idx);
                    rs_start_next = best.start;
                    rs_size_next  = best.size;
                    if ((best.size > amount_reg) && !table_full)
                    begin
                        rs_status_next = STATUS_SPLIT;
                        if (count_m1[IDX_W-1:0] > best_idx)
                        begin
                            shift_addr_next   = count_m1[IDX_W-1:0];
                            shift_active_next = 1'b1;
                            state_next        = S_SHIFT;
                        end
                        else
                        begin
                            state_next = S_WR_REM;
                        end
                    end
                    else
                    begin
                        // Take the whole block
                        rs_status_next  = STATUS_UNSPLIT;
                        mem_we          = 1'b1;
                        mem_waddr       = best_idx;
                        mem_wdata.start = best.start;
                        mem_wdata.size  = best.size;
                        mem_wdata.used  = 1'b1;
                        state_next      = S_FINISH;
                    end
                end
            end

            S_SHIFT:
            begin
                // Read from the top down, write each row one place higher
                rd_addr         = shift_addr_reg;
                pipe_valid_next = shift_active_reg;
                pipe_idx_next   = shift_addr_reg;
                if (shift_active_reg)
                begin
                    if (shift_addr_reg == best_idx_p1)
                    begin
                        shift_active_next = 1'b0;
                    end
                    else
                    begin
                        shift_addr_next = shift_addr_reg - 1'b1;
                    end
                end
                if (pipe_valid_reg)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = pipe_idx_reg + 1'b1;
                    mem_wdata = rd_data_reg;
                end
                if (!shift_active_reg && !pipe_valid_reg)
                begin
                    state_next = S_WR_REM;
                end
            end

            S_WR_REM:
            begin
                mem_we          = 1'b1;
                mem_waddr       = best_idx_p1;
                mem_wdata.start = best.start + {{(ADDR_W-SIZE_W){1'b0}}, amount_reg};
                mem_wdata.size  = best.size - amount_reg;
                mem_wdata.used  = 1'b0;
                state_next      = S_WR_BEST;
            end

            S_WR_BEST:
            begin
                mem_we           = 1'b1;
                mem_waddr        = best_idx;
                mem_wdata.start  = best.start;
                mem_wdata.size   = amount_reg;
                mem_wdata.used   = 1'b1;
                entry_count_next = entry_count_reg + 1'b1;
                state_next       = S_FINISH;
            end

            S_FINISH:
            begin
                // Hold until the output register is free
                if (out_free)
                begin
                    result_valid_next = 1'b1;
                    status_next       = rs_status_reg;
                    block_index_next  = rs_index_reg;
                    block_start_next  = rs_start_reg;
                    block_size_next   = rs_size_reg;
                    state_next        = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg           <= S_IDLE;
            entry_count_reg     <= '0;
            next_load_start_reg <= '0;
            scan_idx_reg        <= '0;
            pipe_valid_reg      <= 1'b0;
            shift_active_reg    <= 1'b0;
            result_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg           <= state_next;
            entry_count_reg     <= entry_count_next;
            next_load_start_reg <= next_load_start_next;
            scan_idx_reg        <= scan_idx_next;
            pipe_valid_reg      <= pipe_valid_next;
            shift_active_reg    <= shift_active_next;
            result_valid_reg    <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pipe_idx_reg    <= pipe_idx_next;
        shift_addr_reg  <= shift_addr_next;
        amount_reg      <= amount_next;
        rs_status_reg   <= rs_status_next;
        rs_index_reg    <= rs_index_next;
        rs_start_reg    <= rs_start_next;
        rs_size_reg     <= rs_size_next;
        status_reg      <= status_next;
        block_index_reg <= block_index_next;
        block_start_reg <= block_start_next;
        block_size_reg  <= block_size_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            table_mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= table_mem[rd_addr];
    end

    assign result_valid = result_valid_reg;
    assign status       = status_reg;
    assign block_index  = block_index_reg;
    assign block_start  = block_start_reg;
    assign block_size   = block_size_reg;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        entry_count_reg <= MAX_CNT)
        else $error("block count exceeds table depth");

    a_load_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (item_xfer && !operation && !table_full)
        |=> (entry_count_reg == $past(entry_count_reg) + 1'b1))
        else $error("accepted load did not grow the table");

    a_scan_drained: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DECIDE) |-> !pipe_valid_reg)
        else $error("decision taken with a read still in flight");

    a_shift_above_best: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SHIFT && pipe_valid_reg) |-> (pipe_idx_reg > best_idx))
        else $error("shift touched a row at or below the chosen block");
`endif

endmodule

/* rtl/wfba_best.sv */
// Compare unit that tracks the largest free block that fits the request during a scan.
module wfba_best
    import wfba_pkg::*;
#(
    parameter int IDX_W = 5
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              clear,
    input  logic              valid,
    input  logic [IDX_W-1:0]  idx,
    input  entry_t            entry,
    input  logic [SIZE_W-1:0] amount,
    output best_t             best,
    output logic [IDX_W-1:0]  best_idx
);

    best_t            best_reg;
    best_t            best_next;
    logic [IDX_W-1:0] best_idx_reg;
    logic [IDX_W-1:0] best_idx_next;
    logic             take;

    // Strictly larger wins, so the lowest index keeps a tie
    assign take = valid && !entry.used && (entry.size >= amount)
                  && (!best_reg.found || (entry.size > best_reg.size));

    always_comb
    begin
        best_next     = best_reg;
        best_idx_next = best_idx_reg;
        if (clear)
        begin
            best_next.found = 1'b0;
        end
        else if (take)
        begin
            best_next.found = 1'b1;
            best_next.start = entry.start;
            best_next.size  = entry.size;
            best_idx_next   = idx;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            best_reg     <= '0;
            best_idx_reg <= '0;
        end
        else
        begin
            best_reg     <= best_next;
            best_idx_reg <= best_idx_next;
        end
    end

    assign best     = best_reg;
    assign best_idx = best_idx_reg;

endmodule
